[sv/decision_tree_classify_defines.svh]
// assertion macros of the decision tree classifier checker
// no dependencies; included by dtc_checker.sv, which holds concurrent assertions
`ifndef DECISION_TREE_CLASSIFY_DEFINES_SVH
`define DECISION_TREE_CLASSIFY_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DTC_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("dtc assertion failed");

// next-cycle implication, disabled while reset is asserted
`define DTC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dtc assertion failed");

`endif

[sv/dtc_pkg.sv]
// types, codes and helpers of the decision tree classifier
// no dependencies; used by every module of the block
package dtc_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned FSEL_W  = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CLASS_W = 16;
  localparam int unsigned FRAC_W  = 16;

  // command codes of an input transaction
  typedef enum logic [1:0] {
    CMD_WR_NODE  = 2'd0,
    CMD_WR_FEAT  = 2'd1,
    CMD_CLASSIFY = 2'd2
  } cmd_e;

  // walk sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_CMP
  } state_e;

  // one node table entry, 53 bits
  typedef struct packed {
    logic              is_leaf;
    logic [FSEL_W-1:0] feature;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
  } node_t;

  // integer part of a q16.16 value, truncated toward zero
  function automatic logic [CLASS_W-1:0] trunc_q16(input logic [VAL_W-1:0] bits);
    logic [VAL_W-1:0]   neg;
    logic [CLASS_W-1:0] mag;
    neg = VAL_W'(0) - bits;
    mag = neg[VAL_W-1:FRAC_W];
    if (bits[VAL_W-1]) begin
      trunc_q16 = CLASS_W'(0) - mag;
    end else begin
      trunc_q16 = bits[VAL_W-1:FRAC_W];
    end
  endfunction

endpackage

[sv/dtc_node_table.sv]
// node table memory: one write port, one registered read port
// depends on dtc_pkg for the node entry type
module dtc_node_table #(
  parameter int unsigned NODES = 256,
  parameter int unsigned NW    = 8
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [NW-1:0] wr_addr_i,
  input  dtc_pkg::node_t wr_data_i,
  input  logic          rd_en_i,
  input  logic [NW-1:0] rd_addr_i,
  output dtc_pkg::node_t rd_data_o
);

  dtc_pkg::node_t mem [NODES];
  dtc_pkg::node_t rd_data_q;

  // synchronous write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/decision_tree_classify.sv]
// decision tree classifier top level: walk sequencer and feature store
// depends on dtc_pkg and dtc_node_table
//
// Usage:
//   Input transactions are accepted at a rising edge with start_i high and
//   busy_o low. cmd_i selects write node, write feature or classify; the
//   fields a command does not use are ignored, cmd 3 does nothing.
//   Write node and write feature never raise busy_o.
//   A classify raises busy_o and walks the tree from the root register.
//   For each inner node a node table read is followed by a feature store
//   read and the signed compare; the node that ends the walk needs only its
//   node table read. At most MAX_DEPTH nodes are read per classify. The
//   result strobe result_valid_o is high in the cycle where busy_o has just
//   dropped, so the next transaction may be accepted from then on.
//   If no leaf is found within MAX_DEPTH reads, depth_error_o is set,
//   class_value_o is zero and leaf_index_o names the last node read.
//   The result is held for exactly one cycle; the receiver cannot stall.
//   The root register is written on the cfg channel (always ready).
//   The user must write it only while idle; the block does not enforce this.
//   Reset clears the sequencer and the root register; the node and feature
//   memories are not cleared; an entry read before its first write is undefined.
module decision_tree_classify #(
  parameter int unsigned NODES     = 256,
  parameter int unsigned FEATURES  = 16,
  parameter int unsigned MAX_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         node_index_i,
  input  logic               node_is_leaf_i,
  input  logic [3:0]         node_feature_i,
  input  logic signed [31:0] node_value_i,
  input  logic [7:0]         node_left_i,
  input  logic [7:0]         node_right_i,
  input  logic [3:0]         feature_index_i,
  input  logic signed [31:0] feature_value_i,
  // result channel
  output logic               result_valid_o,
  output logic signed [15:0] class_value_o,
  output logic [7:0]         leaf_index_o,
  output logic               depth_error_o,
  // configuration channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned FW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int unsigned DW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned IDX_RANGE  = 1 << dtc_pkg::IDX_W;
  localparam int unsigned FSEL_RANGE = 1 << dtc_pkg::FSEL_W;

  dtc_pkg::state_e state_q, state_d;
  logic [NW-1:0]   cur_q, cur_d;
  logic [DW-1:0]   depth_q, depth_d;
  logic [7:0]      root_q;
  logic            res_valid_q, res_valid_d;
  logic [15:0]     class_q, class_d;
  logic [7:0]      leaf_q, leaf_d;
  logic            err_q, err_d;

  // index reduction tables, worked out at elaboration
  logic [NW-1:0] node_mod [IDX_RANGE];
  logic [FW-1:0] feat_mod [FSEL_RANGE];

  for (genvar g = 0; g < IDX_RANGE; g++) begin : g_node_mod
    assign node_mod[g] = NW'(g % NODES);
  end
  for (genvar g = 0; g < FSEL_RANGE; g++) begin : g_feat_mod
    assign feat_mod[g] = FW'(g % FEATURES);
  end

  // node table
  dtc_pkg::node_t node_wr_data;
  dtc_pkg::node_t node_rd;
  logic           node_wr_en;
  logic           node_rd_en;
  logic [NW-1:0]  node_rd_addr;
  logic [7:0]     addr_sel;

  assign node_wr_data.is_leaf = node_is_leaf_i;
  assign node_wr_data.feature = node_feature_i;
  assign node_wr_data.value   = node_value_i;
  assign node_wr_data.left    = node_left_i;
  assign node_wr_data.right   = node_right_i;

  dtc_node_table #(
    .NODES (NODES),
    .NW    (NW)
  ) u_node_table (
    .clk_i     (clk_i),
    .wr_en_i   (node_wr_en),
    .wr_addr_i (node_mod[node_index_i]),
    .wr_data_i (node_wr_data),
    .rd_en_i   (node_rd_en),
    .rd_addr_i (node_rd_addr),
    .rd_data_o (node_rd)
  );

  // feature store
  logic [31:0]   feat_mem [FEATURES];
  logic [31:0]   feat_rd_q;
  logic          feat_wr_en;
  logic          feat_rd_en;
  logic [FW-1:0] feat_rd_addr;

  assign feat_rd_addr = feat_mod[node_rd.feature];

  always_ff @(posedge clk_i) begin
    if (feat_wr_en) begin
      feat_mem[feat_mod[feature_index_i]] <= feature_value_i;
    end
    if (feat_rd_en) begin
      feat_rd_q <= feat_mem[feat_rd_addr];
    end
  end

  // child selection: left when feature <= threshold, signed
  logic go_left;
  assign go_left  = $signed(feat_rd_q) <= $signed(node_rd.value);
  assign addr_sel = (state_q == dtc_pkg::ST_CMP)
                    ? (go_left ? node_rd.left : node_rd.right) : root_q;
  assign node_rd_addr = node_mod[addr_sel];

  // sequencer next state and memory controls
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    res_valid_d = 1'b0;
    class_d     = class_q;
    leaf_d      = leaf_q;
    err_d       = err_q;
    node_wr_en  = 1'b0;
    node_rd_en  = 1'b0;
    feat_wr_en  = 1'b0;
    feat_rd_en  = 1'b0;
    case (state_q)
      dtc_pkg::ST_IDLE: begin
        if (start_i) begin
          case (cmd_i)
            dtc_pkg::CMD_WR_NODE: begin
              node_wr_en = 1'b1;
            end
            dtc_pkg::CMD_WR_FEAT: begin
              feat_wr_en = 1'b1;
            end
            dtc_pkg::CMD_CLASSIFY: begin
              node_rd_en = 1'b1;
              cur_d      = node_rd_addr;
              depth_d    = '0;
              state_d    = dtc_pkg::ST_NODE;
            end
            default: begin
            end
          endcase
        end
      end
      dtc_pkg::ST_NODE: begin
        if (node_rd.is_leaf) begin
          res_valid_d = 1'b1;
          class_d     = dtc_pkg::trunc_q16(node_rd.value);
          leaf_d      = 8'(cur_q);
          err_d       = 1'b0;
          state_d     = dtc_pkg::ST_IDLE;
        end else if (depth_q == DW'(MAX_DEPTH - 1)) begin
          res_valid_d = 1'b1;
          class_d     = '0;
          leaf_d      = 8'(cur_q);
          err_d       = 1'b1;
          state_d     = dtc_pkg::ST_IDLE;
        end else begin
          feat_rd_en = 1'b1;
          state_d    = dtc_pkg::ST_CMP;
        end
      end
      dtc_pkg::ST_CMP: begin
        node_rd_en = 1'b1;
        cur_d      = node_rd_addr;
        depth_d    = depth_q + DW'(1);
        state_d    = dtc_pkg::ST_NODE;
      end
      default: begin
        state_d = dtc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtc_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
      root_q      <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        root_q <= cfg_data_i;
      end
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    depth_q <= depth_d;
    class_q <= class_d;
    leaf_q  <= leaf_d;
    err_q   <= err_d;
  end

  assign busy_o         = (state_q != dtc_pkg::ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign class_value_o  = class_q;
  assign leaf_index_o   = leaf_q;
  assign depth_error_o  = err_q;

endmodule

[sv/dtc_checker.sv]
// port-level checks of the decision tree classifier, bound to the top level
// depends on dtc_pkg and decision_tree_classify_defines.svh
`include "decision_tree_classify_defines.svh"

module dtc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic [1:0]         cmd_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input logic signed [15:0] class_value_o,
  input logic               depth_error_o
);

  logic classify_acc;
  assign classify_acc = start_i && !busy_o && (cmd_i == dtc_pkg::CMD_CLASSIFY);

  // an accepted classify starts a walk
  `DTC_ASSERT_NEXT(a_classify_busy, clk_i, rst_ni, classify_acc, busy_o)

  // every walk ends with a result transaction
  `DTC_ASSERT_NOW(a_end_result, clk_i, rst_ni, $fell(busy_o), result_valid_o)

  // a result shows up only once the walk is over
  `DTC_ASSERT_NOW(a_result_idle, clk_i, rst_ni, result_valid_o, !busy_o)

  // result strobes never come back to back
  `DTC_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o)

  // a depth error carries no class
  `DTC_ASSERT_NOW(a_err_class, clk_i, rst_ni, result_valid_o && depth_error_o,
    class_value_o == 16'sd0)

endmodule

bind decision_tree_classify dtc_checker u_dtc_checker (.*);

[tb/sv/tb_top.sv]
// self-checking testbench of the decision tree classifier
// depends on dtc_pkg and decision_tree_classify; predicts every classify result itself
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned NODES      = 256;
  localparam int unsigned FEATURES   = 16;
  localparam int unsigned MAX_DEPTH  = 16;
  localparam int unsigned QUIET_MAX  = 1000;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  // one classify result
  typedef struct {
    logic signed [15:0] class_value;
    logic [7:0]         leaf_index;
    logic               depth_error;
  } class_result_t;

  // one command transaction with the result it must cause
  typedef struct {
    logic [1:0]         cmd;
    logic [7:0]         node_index;
    logic               node_is_leaf;
    logic [3:0]         node_feature;
    logic signed [31:0] node_value;
    logic [7:0]         node_left;
    logic [7:0]         node_right;
    logic [3:0]         feature_index;
    logic signed [31:0] feature_value;
    bit                 has_result;
    class_result_t      result;
  } tree_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         cmd_i = '0;
  logic [7:0]         node_index_i = '0;
  logic               node_is_leaf_i = 1'b0;
  logic [3:0]         node_feature_i = '0;
  logic signed [31:0] node_value_i = '0;
  logic [7:0]         node_left_i = '0;
  logic [7:0]         node_right_i = '0;
  logic [3:0]         feature_index_i = '0;
  logic signed [31:0] feature_value_i = '0;
  logic               result_valid_o;
  logic signed [15:0] class_value_o;
  logic [7:0]         leaf_index_o;
  logic               depth_error_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_data_i = '0;

  // predictor state: node table, feature store, root and which entries hold data
  dtc_pkg::node_t tree_mem [NODES];
  logic [31:0]    feat_mem [FEATURES];
  bit             node_set [NODES];
  bit             feat_set [FEATURES];
  logic [7:0]     root_reg = '0;

  tree_cmd_t     pending_cmds [$];
  class_result_t expected_classes [$];
  tree_cmd_t     cmd_on_bus;
  int unsigned   gap_left = 0;
  bit            gaps_on = 1'b0;
  int unsigned   err_count = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   cmds_queued = 0;

  decision_tree_classify #(
    .NODES     (NODES),
    .FEATURES  (FEATURES),
    .MAX_DEPTH (MAX_DEPTH)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cmd_i           (cmd_i),
    .node_index_i    (node_index_i),
    .node_is_leaf_i  (node_is_leaf_i),
    .node_feature_i  (node_feature_i),
    .node_value_i    (node_value_i),
    .node_left_i     (node_left_i),
    .node_right_i    (node_right_i),
    .feature_index_i (feature_index_i),
    .feature_value_i (feature_value_i),
    .result_valid_o  (result_valid_o),
    .class_value_o   (class_value_o),
    .leaf_index_o    (leaf_index_o),
    .depth_error_o   (depth_error_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // walk the tree from the root; legal is low when an unwritten entry would be read
  function automatic void walk_tree(output bit legal, output bit need_feat,
                                    output logic [7:0] need_idx,
                                    output class_result_t res);
    logic [7:0]         cur;
    dtc_pkg::node_t     nd;
    logic signed [31:0] leaf_int;
    cur       = root_reg;
    legal     = 1'b1;
    need_feat = 1'b0;
    need_idx  = '0;
    for (int d = 0; d < MAX_DEPTH; d++) begin
      if (!node_set[cur]) begin
        legal    = 1'b0;
        need_idx = cur;
        return;
      end
      nd = tree_mem[cur];
      if (nd.is_leaf) begin
        // signed division truncates toward zero
        leaf_int = $signed(nd.value) / 32'sd65536;
        res = '{leaf_int[15:0], cur, 1'b0};
        return;
      end
      if (!feat_set[nd.feature]) begin
        legal     = 1'b0;
        need_feat = 1'b1;
        need_idx  = {4'd0, nd.feature};
        return;
      end
      if (d == MAX_DEPTH - 1) break;
      cur = ($signed(feat_mem[nd.feature]) <= $signed(nd.value)) ? nd.left : nd.right;
    end
    res = '{16'sd0, cur, 1'b1};
  endfunction

  // apply a transaction to the predictor and attach its expected result
  function automatic void apply_cmd(inout tree_cmd_t c);
    bit         legal, need_feat;
    logic [7:0] need_idx;
    c.has_result = 1'b0;
    case (c.cmd)
      dtc_pkg::CMD_WR_NODE: begin
        tree_mem[c.node_index] = '{c.node_is_leaf, c.node_feature, c.node_value,
                                   c.node_left, c.node_right};
        node_set[c.node_index] = 1'b1;
      end
      dtc_pkg::CMD_WR_FEAT: begin
        feat_mem[c.feature_index] = c.feature_value;
        feat_set[c.feature_index] = 1'b1;
      end
      dtc_pkg::CMD_CLASSIFY: begin
        walk_tree(legal, need_feat, need_idx, c.result);
        c.has_result = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // all fields but the command random, so unused fields carry noise; the command is the unused code
  function automatic tree_cmd_t random_fields();
    tree_cmd_t c;
    c.cmd           = CMD_UNUSED;
    c.node_index    = 8'($urandom);
    c.node_is_leaf  = 1'($urandom);
    c.node_feature  = 4'($urandom);
    c.node_value    = $urandom;
    c.node_left     = 8'($urandom);
    c.node_right    = 8'($urandom);
    c.feature_index = 4'($urandom);
    c.feature_value = $urandom;
    return c;
  endfunction

  // q16.16 values: extremes, small values near zero, or anything
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      4, 5: return $signed($urandom_range(0, 8 * 65536)) - 32'sd262144;
      default: return $urandom;
    endcase
  endfunction

  // children mostly stay close to the root so walks go deep and loop
  function automatic logic [7:0] pick_child();
    if ($urandom_range(0, 3) != 0) return root_reg + 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_cmd(input tree_cmd_t c);
    apply_cmd(c);
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic write_node(input logic [7:0] idx, input logic leaf, input logic [3:0] feat,
                            input logic signed [31:0] val, input logic [7:0] lft,
                            input logic [7:0] rgt);
    tree_cmd_t c;
    c = random_fields();
    c.cmd          = dtc_pkg::CMD_WR_NODE;
    c.node_index   = idx;
    c.node_is_leaf = leaf;
    c.node_feature = feat;
    c.node_value   = val;
    c.node_left    = lft;
    c.node_right   = rgt;
    queue_cmd(c);
  endtask

  task automatic write_feat(input logic [3:0] idx, input logic signed [31:0] val);
    tree_cmd_t c;
    c = random_fields();
    c.cmd           = dtc_pkg::CMD_WR_FEAT;
    c.feature_index = idx;
    c.feature_value = val;
    queue_cmd(c);
  endtask

  task automatic random_node(input logic [7:0] idx);
    write_node(idx, $urandom_range(0, 99) < 35, 4'($urandom), rand_q16(), pick_child(),
               pick_child());
  endtask

  // classify, first writing every entry the walk would read unwritten
  task automatic queue_classify();
    bit            legal, need_feat;
    logic [7:0]    need_idx;
    class_result_t res;
    tree_cmd_t     c;
    walk_tree(legal, need_feat, need_idx, res);
    while (!legal) begin
      if (need_feat) write_feat(need_idx[3:0], rand_q16());
      else random_node(need_idx);
      walk_tree(legal, need_feat, need_idx, res);
    end
    c = random_fields();
    c.cmd = dtc_pkg::CMD_CLASSIFY;
    queue_cmd(c);
  endtask

  task automatic queue_noop();
    tree_cmd_t c;
    c = random_fields();
    queue_cmd(c);
  endtask

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= MAX_SHOWN) $display("ERROR: %s", msg);
  endtask

  // idle means no queued command, nothing in flight and no result owed
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || start_i || busy_o || expected_classes.size() != 0);
    // writes give no result, let them settle
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_root(input logic [7:0] r);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    root_reg = r;
  endtask

  task automatic run_phase(input logic [7:0] r, input int unsigned n, input bit gaps);
    int unsigned pick;
    write_root(r);
    @(negedge clk_i);
    gaps_on = gaps;
    cmds_queued = 0;
    while (cmds_queued < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) queue_classify();
      else if (pick < 65) random_node(($urandom_range(0, 2) != 0) ? pick_child() : 8'($urandom));
      else if (pick < 82) write_feat(4'($urandom), rand_q16());
      else if (pick < 87) queue_noop();
      else random_node(root_reg);
    end
    wait_drained();
  endtask

  // command driver: holds start until accepted, idles in random bursts when gaps are on
  always @(posedge clk_i or negedge rst_ni) begin : driver
    tree_cmd_t c;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o && cmd_on_bus.has_result) begin
        expected_classes.push_back(cmd_on_bus.result);
      end
      if (start_i && busy_o) begin
        // hold the transaction until taken
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start_i  <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(0, 9);
        start_i  <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd_on_bus      <= c;
        cmd_i           <= c.cmd;
        node_index_i    <= c.node_index;
        node_is_leaf_i  <= c.node_is_leaf;
        node_feature_i  <= c.node_feature;
        node_value_i    <= c.node_value;
        node_left_i     <= c.node_left;
        node_right_i    <= c.node_right;
        feature_index_i <= c.feature_index;
        feature_value_i <= c.feature_value;
        start_i         <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor: compare each strobe with the oldest expectation
  always @(posedge clk_i) begin : monitor
    class_result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_classes.size() == 0) begin
        log_error($sformatf("unexpected result class %0d leaf %0d depth_error %0b",
                            class_value_o, leaf_index_o, depth_error_o));
      end else begin
        want = expected_classes.pop_front();
        if (class_value_o !== want.class_value)
          log_error($sformatf("class_value expected %0d, got %0d",
                              want.class_value, class_value_o));
        if (leaf_index_o !== want.leaf_index)
          log_error($sformatf("leaf_index expected %0d, got %0d",
                              want.leaf_index, leaf_index_o));
        if (depth_error_o !== want.depth_error)
          log_error($sformatf("depth_error expected %0b, got %0b",
                              want.depth_error, depth_error_o));
      end
    end
  end

  // watchdog: too long without any transaction means the block hangs
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes of values, equal compare, truncation, root leaf, depth limit
    write_root(8'd0);
    @(negedge clk_i);
    gaps_on = 1'b1;
    write_feat(4'd0, 32'sh7fff_ffff);
    write_feat(4'd15, 32'sh8000_0000);
    write_feat(4'd1, 32'sd0);
    write_feat(4'd2, -32'sd1);
    write_node(8'd0, 1'b0, 4'd0, 32'sh7fff_ffff, 8'd1, 8'd255);
    write_node(8'd1, 1'b0, 4'd15, 32'sh8000_0000, 8'd2, 8'd3);
    write_node(8'd2, 1'b1, 4'd0, 32'sh8000_0000, 8'd0, 8'd0);
    queue_classify();
    write_node(8'd1, 1'b0, 4'd0, 32'sh7fff_fffe, 8'd2, 8'd255);
    write_node(8'd255, 1'b1, 4'd15, 32'sh7fff_ffff, 8'd255, 8'd255);
    queue_classify();
    write_node(8'd255, 1'b1, 4'd0, 32'shffff_8000, 8'd0, 8'd0);
    queue_classify();
    write_node(8'd255, 1'b1, 4'd0, 32'shfffe_8000, 8'd0, 8'd0);
    queue_classify();
    queue_noop();
    write_node(8'd0, 1'b1, 4'd0, 32'sh0001_8000, 8'd0, 8'd0);
    queue_classify();
    write_node(8'd0, 1'b0, 4'd2, -32'sd1, 8'd0, 8'd0);
    queue_classify();
    wait_drained();

    // random phases over several roots; the second and the last run without gaps
    run_phase(8'd255, 290, 1'b1);
    run_phase(8'($urandom), 290, 1'b0);
    run_phase(8'd0, 290, 1'b1);
    run_phase(8'($urandom), 290, 1'b0);

    repeat (2 * MAX_DEPTH + 8) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
